// ===== design/varint_length_field_deframer_defines.svh =====
// Assertion macros shared by the deframer RTL.
`ifndef VARINT_LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`define VARINT_LENGTH_FIELD_DEFRAMER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define VLFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication, disabled while reset is asserted.
`define VLFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define VLFD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define VLFD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)
`endif
`endif

// ===== design/vlfd_pkg.sv =====
// Shared types and constants for the length-prefixed field deframer.
package vlfd_pkg;

    localparam int CFG_W       = 5;
    localparam int IDX_W       = 4;
    localparam int FLEN_W      = 32;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [CFG_W-1:0] FIELD_LIMIT_RST = 5'd16;
    localparam logic [IDX_W-1:0] IDX_MAX         = 4'd15;

    typedef enum logic [1:0] {
        KIND_OPCODE,
        KIND_FLAGS,
        KIND_LENGTH,
        KIND_PAYLOAD
    } kind_t;

    typedef enum logic [1:0] {
        ERR_NONE,
        ERR_TRUNC,
        ERR_TOO_LONG,
        ERR_TOO_MANY
    } err_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         data;
        logic [IDX_W-1:0]   field_index;
        logic               length_done;
        logic [FLEN_W-1:0]  field_length;
        logic               field_end;
        logic               packet_end;
        err_t               error;
    } result_t;

endpackage

// ===== design/varint_length_field_deframer.sv =====
// Top level of the base-128 length-prefixed field deframer.
//
//  port group | dir | payload
//  s_*        | in  | tdata[7:0] raw byte, tlast final byte of packet
//  m_*        | out | tdata classified byte word, tuser kind, tlast packet end
//  cfg_*      | in  | wdata field limit, written while wen is high
//
// One byte per clock sustained while s_tready is high; the classifier updates
// all packet state in the cycle a byte is taken. Each result is written into
// the queue and then into the output register. Reset is synchronous, active
// low, and clears packet state and sets the field limit to 16.
// A stalled output fills the two-word queue, after which s_tready drops.
module varint_length_field_deframer #(
    parameter int MAX_FIELDS  = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // in_byte
    input  logic                       s_tlast,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // out_byte[7:0], field_index[11:8], length_done[12], field_length[44:13],
    // field_end[45], error[47:46]
    output logic [47:0]                m_tdata,
    output logic [1:0]                 m_tuser,   // kind
    output logic                       m_tlast,
    input  logic                       cfg_wen,
    input  logic [vlfd_pkg::CFG_W-1:0] cfg_wdata
);
    import vlfd_pkg::*;

    result_t front_res;
    result_t queue_res;
    logic    queue_valid;
    logic    back_ready;

    vlfd_front #(
        .MAX_FIELDS (MAX_FIELDS),
        .LENGTH_BITS(LENGTH_BITS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (s_tvalid && s_tready),
        .in_byte  (s_tdata),
        .last_byte(s_tlast),
        .cfg_wen  (cfg_wen),
        .cfg_wdata(cfg_wdata),
        .res      (front_res)
    );

    vlfd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_res   (front_res),
        .out_valid(queue_valid),
        .out_ready(back_ready),
        .out_res  (queue_res)
    );

    vlfd_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_valid(queue_valid),
        .in_ready(back_ready),
        .in_res  (queue_res),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .m_tlast (m_tlast)
    );

endmodule

// ===== design/vlfd_front.sv =====
// Front end: byte classifier, length decoder and packet state.
`include "varint_length_field_deframer_defines.svh"
module vlfd_front #(
    parameter int MAX_FIELDS  = 16,
    parameter int LENGTH_BITS = 32
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      accept,
    input  logic [7:0]                in_byte,
    input  logic                      last_byte,
    input  logic                      cfg_wen,
    input  logic [vlfd_pkg::CFG_W-1:0] cfg_wdata,
    output vlfd_pkg::result_t         res
);
    import vlfd_pkg::*;

    localparam int GROUPS = (LENGTH_BITS + 6) / 7;
    localparam int GC_W   = $clog2(GROUPS + 1);
    localparam int WIDE_W = 7 * GROUPS + 7;
    localparam int FC_W   = $clog2(MAX_FIELDS + 1);
    localparam logic [CFG_W-1:0] MAX_F5 = CFG_W'(MAX_FIELDS);

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_FLAGS,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DRAIN
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [LENGTH_BITS-1:0] acc_reg, acc_next;
    logic [GC_W-1:0]        gc_reg, gc_next;
    logic [LENGTH_BITS-1:0] rem_reg, rem_next;
    logic [FC_W-1:0]        fc_reg, fc_next;
    err_t                   err_reg, err_next;
    logic [CFG_W-1:0]       limit_reg;

    logic [CFG_W-1:0]       lim_eff;
    logic [CFG_W-1:0]       fc5;
    logic [IDX_W-1:0]       idx_clamp;
    logic [WIDE_W-1:0]      wide;
    logic                   over;
    logic [LENGTH_BITS-1:0] acc_new;

    always_comb begin
        if (limit_reg == '0) begin
            lim_eff = CFG_W'(1);
        end else if (limit_reg > MAX_F5) begin
            lim_eff = MAX_F5;
        end else begin
            lim_eff = limit_reg;
        end
        fc5       = CFG_W'(fc_reg);
        idx_clamp = (fc5 > CFG_W'(IDX_MAX)) ? IDX_MAX : fc5[IDX_W-1:0];
    end

    // place the seven data bits at the current group position
    always_comb begin
        wide = '0;
        for (int g = 0; g <= GROUPS; g++) begin
            if (gc_reg == GC_W'(g)) begin
                wide = WIDE_W'(in_byte[6:0]) << (7 * g);
            end
        end
        over    = |wide[WIDE_W-1:LENGTH_BITS];
        acc_new = acc_reg | wide[LENGTH_BITS-1:0];
    end

    always_comb begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        gc_next    = gc_reg;
        rem_next   = rem_reg;
        fc_next    = fc_reg;
        err_next   = err_reg;
        res            = '0;
        res.kind       = KIND_OPCODE;
        res.data       = in_byte;
        res.packet_end = last_byte;

        unique case (phase_reg)
            PH_OPCODE: begin
                res.kind = KIND_OPCODE;
                if (last_byte) begin
                    err_next = ERR_TRUNC;
                end else begin
                    phase_next = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                res.kind   = KIND_FLAGS;
                phase_next = PH_LENGTH;
                acc_next   = '0;
                gc_next    = '0;
            end
            PH_LENGTH: begin
                res.kind        = KIND_LENGTH;
                res.field_index = idx_clamp;
                if (gc_reg == '0 && fc5 >= lim_eff) begin
                    err_next = ERR_TOO_MANY;
                end else if (over) begin
                    err_next = ERR_TOO_LONG;
                end else begin
                    if (gc_reg != GC_W'(GROUPS)) begin
                        gc_next = gc_reg + GC_W'(1);
                    end
                    if (in_byte[7]) begin
                        acc_next = acc_new;
                        if (last_byte) begin
                            err_next = ERR_TRUNC;
                        end
                    end else begin
                        res.length_done  = 1'b1;
                        res.field_length = FLEN_W'(acc_new);
                        acc_next         = '0;
                        if (acc_new == '0) begin
                            res.field_end = 1'b1;
                            fc_next       = fc_reg + FC_W'(1);
                            gc_next       = '0;
                        end else begin
                            rem_next   = acc_new;
                            phase_next = PH_PAYLOAD;
                            if (last_byte) begin
                                err_next = ERR_TRUNC;
                            end
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                res.kind        = KIND_PAYLOAD;
                res.field_index = idx_clamp;
                rem_next        = rem_reg - LENGTH_BITS'(1);
                if (rem_reg == LENGTH_BITS'(1)) begin
                    res.field_end = 1'b1;
                    fc_next       = fc_reg + FC_W'(1);
                    phase_next    = PH_LENGTH;
                    acc_next      = '0;
                    gc_next       = '0;
                end else if (last_byte) begin
                    err_next = ERR_TRUNC;
                end
            end
            PH_DRAIN: begin
                res.kind        = KIND_PAYLOAD;
                res.field_index = idx_clamp;
            end
            default: begin
                res.kind        = KIND_PAYLOAD;
                res.field_index = idx_clamp;
                phase_next      = PH_DRAIN;
            end
        endcase

        // hold the first error code and drop the rest of the packet
        if (err_next != ERR_NONE) begin
            phase_next = PH_DRAIN;
        end
        res.error = err_next;

        if (last_byte) begin
            phase_next = PH_OPCODE;
            acc_next   = '0;
            gc_next    = '0;
            rem_next   = '0;
            fc_next    = '0;
            err_next   = ERR_NONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_OPCODE;
            acc_reg   <= '0;
            gc_reg    <= '0;
            rem_reg   <= '0;
            fc_reg    <= '0;
            err_reg   <= ERR_NONE;
            limit_reg <= FIELD_LIMIT_RST;
        end else begin
            if (accept) begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                gc_reg    <= gc_next;
                rem_reg   <= rem_next;
                fc_reg    <= fc_next;
                err_reg   <= err_next;
            end
            if (cfg_wen) begin
                limit_reg <= cfg_wdata;
            end
        end
    end

    `VLFD_ASSERT_IMP(a_drain_iff_error, aclk, aresetn, 1'b1, (phase_reg == PH_DRAIN) == (err_reg != ERR_NONE), "drain phase and error code disagree")
    `VLFD_ASSERT_NXT(a_error_sticky, aclk, aresetn, accept && !last_byte && err_reg != ERR_NONE, err_reg == $past(err_reg), "error code changed before packet end")
    `VLFD_ASSERT_IMP(a_field_count_bound, aclk, aresetn, 1'b1, fc5 <= MAX_F5, "field counter beyond maximum")

endmodule

// ===== design/vlfd_queue.sv =====
// Short result queue between the classifier and the output stage.
`include "varint_length_field_deframer_defines.svh"
module vlfd_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vlfd_pkg::result_t in_res,
    output logic              out_valid,
    input  logic              out_ready,
    output vlfd_pkg::result_t out_res
);
    import vlfd_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    result_t          q_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push, pop;

    assign in_ready  = count_reg != CNT_W'(QUEUE_DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_res   = q_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            q_mem[wr_ptr_reg] <= in_res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : wr_ptr_reg + PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                       : rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (pop && !push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    `VLFD_ASSERT_IMP(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
    `VLFD_ASSERT_NXT(a_push_into_empty, aclk, aresetn, push && !pop && count_reg == '0, count_reg == CNT_W'(1) && out_valid, "word pushed into empty queue not visible")

endmodule

// ===== design/vlfd_back.sv =====
// Back end: output register and stream packing of result words.
module vlfd_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              in_valid,
    output logic              in_ready,
    input  vlfd_pkg::result_t in_res,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [47:0]       m_tdata,
    output logic [1:0]        m_tuser,
    output logic              m_tlast
);
    import vlfd_pkg::*;

    logic    valid_reg;
    result_t res_reg;

    // load a new word whenever the register is empty or being drained
    assign in_ready = !valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            res_reg <= in_res;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {res_reg.error, res_reg.field_end, res_reg.field_length,
                       res_reg.length_done, res_reg.field_index, res_reg.data};
    assign m_tuser  = res_reg.kind;
    assign m_tlast  = res_reg.packet_end;

endmodule

// ===== sim/vlfd_checker.sv =====
// Deframer checker: predicts the classified word for each accepted byte and compares results.
module vlfd_checker (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    input  logic                       s_tready,
    input  logic [7:0]                 s_tdata,
    input  logic                       s_tlast,
    input  logic                       m_tvalid,
    input  logic                       m_tready,
    input  logic [47:0]                m_tdata,
    input  logic [1:0]                 m_tuser,
    input  logic                       m_tlast,
    input  logic                       cfg_wen,
    input  logic [vlfd_pkg::CFG_W-1:0] cfg_wdata,
    output int                         mismatch_count,
    output int                         pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import vlfd_pkg::*;

    localparam int LENGTH_BITS = 32;
    localparam int MAX_FIELDS  = 16;
    localparam int GROUP_CAP   = 10;

    typedef enum logic [2:0] {
        PH_OPCODE,
        PH_FLAGS,
        PH_LENGTH,
        PH_PAYLOAD,
        PH_DRAIN
    } phase_t;

    phase_t           phase;
    logic [63:0]      len_acc;
    logic [3:0]       groups;
    logic [63:0]      payload_left;
    logic [4:0]       fields_done;
    err_t             err_held;
    logic [CFG_W-1:0] field_limit;

    result_t expected_words[$];
    int      fail_total = 0;

    assign mismatch_count = fail_total;

    function automatic void clear_packet();
        phase        = PH_OPCODE;
        len_acc      = '0;
        groups       = '0;
        payload_left = '0;
        fields_done  = '0;
        err_held     = ERR_NONE;
    endfunction

    function automatic logic [IDX_W-1:0] index_now();
        return (fields_done > 5'd15) ? IDX_MAX : fields_done[IDX_W-1:0];
    endfunction

    // Keep the first error of a packet.
    function automatic void flag_error(err_t code);
        if (err_held == ERR_NONE) err_held = code;
    endfunction

    function automatic result_t classify_byte(logic [7:0] b, logic is_last);
        result_t    r;
        logic [6:0] grp;
        int         shift;
        int         lim;
        logic       over;
        r = '0;
        r.data       = b;
        r.packet_end = is_last;
        lim = field_limit;
        if (lim < 1) lim = 1;
        if (lim > MAX_FIELDS) lim = MAX_FIELDS;
        case (phase)
            PH_OPCODE: begin
                r.kind = KIND_OPCODE;
                if (is_last) flag_error(ERR_TRUNC);
                else phase = PH_FLAGS;
            end
            PH_FLAGS: begin
                r.kind  = KIND_FLAGS;
                phase   = PH_LENGTH;
                len_acc = '0;
                groups  = '0;
            end
            PH_LENGTH: begin
                grp   = b[6:0];
                shift = 7 * groups;
                r.kind        = KIND_LENGTH;
                r.field_index = index_now();
                if (groups == 0 && fields_done >= lim) begin
                    flag_error(ERR_TOO_MANY);
                end else begin
                    if (shift >= LENGTH_BITS)
                        over = (grp != 0);
                    else
                        over = (LENGTH_BITS - shift < 7) && ((grp >> (LENGTH_BITS - shift)) != 0);
                    if (over) begin
                        flag_error(ERR_TOO_LONG);
                    end else begin
                        if (shift < 64) len_acc |= 64'(grp) << shift;
                        if (groups < GROUP_CAP) groups++;
                        if (b[7]) begin
                            if (is_last) flag_error(ERR_TRUNC);
                        end else begin
                            r.length_done  = 1'b1;
                            r.field_length = len_acc[FLEN_W-1:0];
                            if (len_acc == 0) begin
                                r.field_end = 1'b1;
                                fields_done++;
                                groups = '0;
                            end else begin
                                payload_left = len_acc;
                                phase        = PH_PAYLOAD;
                                if (is_last) flag_error(ERR_TRUNC);
                            end
                            len_acc = '0;
                        end
                    end
                end
            end
            PH_PAYLOAD: begin
                r.kind        = KIND_PAYLOAD;
                r.field_index = index_now();
                payload_left--;
                if (payload_left == 0) begin
                    r.field_end = 1'b1;
                    fields_done++;
                    phase   = PH_LENGTH;
                    len_acc = '0;
                    groups  = '0;
                end else if (is_last) begin
                    flag_error(ERR_TRUNC);
                end
            end
            default: begin
                r.kind        = KIND_PAYLOAD;
                r.field_index = index_now();
            end
        endcase
        if (err_held != ERR_NONE) phase = PH_DRAIN;
        r.error = err_held;
        if (is_last) clear_packet();
        return r;
    endfunction

    function automatic string describe(result_t r);
        return $sformatf("kind=%0d byte=%02h idx=%0d ld=%0b len=%08h fe=%0b pe=%0b err=%0d",
                         r.kind, r.data, r.field_index, r.length_done, r.field_length,
                         r.field_end, r.packet_end, r.error);
    endfunction

    always @(posedge aclk) begin
        result_t got;
        result_t want;
        if (!aresetn) begin
            clear_packet();
            field_limit = FIELD_LIMIT_RST;
            expected_words.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.kind         = kind_t'(m_tuser);
                got.data         = m_tdata[7:0];
                got.field_index  = m_tdata[11:8];
                got.length_done  = m_tdata[12];
                got.field_length = m_tdata[44:13];
                got.field_end    = m_tdata[45];
                got.packet_end   = m_tlast;
                got.error        = err_t'(m_tdata[47:46]);
                if (expected_words.size() == 0) begin
                    if (fail_total < 10)
                        $display("unexpected word at %0t: %s", $realtime, describe(got));
                    fail_total++;
                end else begin
                    want = expected_words.pop_front();
                    if (got !== want) begin
                        if (fail_total < 10) begin
                            $display("mismatch at %0t", $realtime);
                            $display("  expected %s", describe(want));
                            $display("  actual   %s", describe(got));
                        end
                        fail_total++;
                    end
                end
            end
            if (cfg_wen) field_limit = cfg_wdata;
            if (s_tvalid && s_tready) expected_words.push_back(classify_byte(s_tdata, s_tlast));
        end
        pending <= expected_words.size();
    end

endmodule

// ===== sim/tb_varint_length_field_deframer.sv =====
// Testbench top for the deframer: reset, packet stimulus, field limit phases and verdict.
module tb_varint_length_field_deframer;
    timeunit 1ns;
    timeprecision 1ps;
    import vlfd_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int PHASE_BYTES  = 235;
    localparam int HOLD_CYCLES  = 400;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;
    logic             s_tlast   = 1'b0;
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [47:0]      m_tdata;
    logic [1:0]       m_tuser;
    logic             m_tlast;
    logic             cfg_wen   = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;

    int         mismatch_count;
    int         pending;
    int         cycle_count  = 0;
    int         bytes_sent   = 0;
    int         words_taken  = 0;
    int         active_limit = 16;
    logic       tx_burst     = 1'b0;
    logic       rx_burst     = 1'b0;
    logic [7:0] pkt_q[$];

    varint_length_field_deframer i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata)
    );

    vlfd_checker i_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tuser        (m_tuser),
        .m_tlast        (m_tlast),
        .cfg_wen        (cfg_wen),
        .cfg_wdata      (cfg_wdata),
        .mismatch_count (mismatch_count),
        .pending        (pending)
    );

    initial begin
        forever #1 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // Result side: random stalls, bursts, and two long hold-offs to fill the block.
    initial begin : result_side
        int gap;
        forever begin
            gap = rx_burst ? 0 : $urandom_range(0, 6);
            if (words_taken == 300 || words_taken == 1100) gap = HOLD_CYCLES;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1 || aresetn !== 1'b1);
            words_taken++;
            if ($urandom_range(0, 39) == 0) rx_burst = ~rx_burst;
        end
    end

    task automatic send_word(input logic [7:0] b, input logic is_last);
        int gap;
        gap = tx_burst ? 0 : $urandom_range(0, 6);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= is_last;
        do @(posedge aclk); while (s_tready !== 1'b1);
        bytes_sent++;
    endtask

    task automatic send_packet();
        foreach (pkt_q[i]) send_word(pkt_q[i], i == pkt_q.size() - 1);
        if ($urandom_range(0, 5) == 0) tx_burst = ~tx_burst;
    endtask

    // Drop valid and wait until every expected word has come back.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending != 0);
    endtask

    task automatic write_limit(input logic [CFG_W-1:0] v);
        cfg_wen   <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_wen <= 1'b0;
        active_limit = (v == 0) ? 1 : (v > 16) ? 16 : int'(v);
    endtask

    // Base-128 length, low group first, with optional zero padding groups.
    function automatic void push_length(logic [63:0] v, int pad);
        int         g;
        logic [6:0] grp;
        g = 1;
        while ((v >> (7 * g)) != 0 && g < 10) g++;
        g += pad;
        for (int i = 0; i < g; i++) begin
            grp = 7'(v >> (7 * i));
            pkt_q.push_back({i < g - 1, grp});
        end
    endfunction

    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return $urandom_range(0, 2);
        if (r < 90) return $urandom_range(3, 12);
        if (r < 97) return $urandom_range(13, 40);
        return $urandom_range(128, 200);
    endfunction

    function automatic void add_field();
        int len;
        int pad;
        len = pick_length();
        pad = ($urandom_range(0, 6) == 0) ? $urandom_range(1, 12) : 0;
        push_length(64'(len), pad);
        repeat (len) pkt_q.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void make_packet();
        int          mode;
        int          cut;
        int          g;
        logic [31:0] big;
        pkt_q.delete();
        pkt_q.push_back(8'($urandom_range(0, 255)));
        pkt_q.push_back(8'($urandom_range(0, 255)));
        mode = $urandom_range(0, 99);
        if (mode < 68) begin
            repeat ($urandom_range(0, active_limit)) add_field();
        end else if (mode < 78) begin
            // truncated anywhere, down to the opcode alone
            repeat ($urandom_range(1, active_limit)) add_field();
            cut = $urandom_range(1, pkt_q.size());
            while (pkt_q.size() > cut) void'(pkt_q.pop_back());
        end else if (mode < 84) begin
            repeat (active_limit + $urandom_range(1, 2)) add_field();
        end else if (mode < 90) begin
            // data bits beyond the length width in the final group
            repeat ($urandom_range(0, 2)) add_field();
            g = $urandom_range(5, 7);
            repeat (g - 1) pkt_q.push_back({1'b1, 7'($urandom_range(0, 127))});
            pkt_q.push_back({1'b0, 7'($urandom_range(g == 5 ? 16 : 1, 127))});
            repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end else if (mode < 95) begin
            big = $urandom;
            if ($urandom_range(0, 1) == 0) big = 32'hffff_ffff - 32'($urandom_range(0, 3));
            push_length(64'(big), 0);
            repeat ($urandom_range(0, 3)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end else begin
            pkt_q.delete();
            repeat ($urandom_range(1, 12)) pkt_q.push_back(8'($urandom_range(0, 255)));
        end
    endfunction

    initial begin : stimulus
        logic [CFG_W-1:0] limit_plan[8];
        limit_plan = '{5'd1, 5'd0, 5'd31, 5'd3, 5'd16,
                       5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)), 5'd17};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // opcode alone, then opcode and flags only
        pkt_q = '{8'hff};
        send_packet();
        pkt_q = '{8'h00, 8'hff};
        send_packet();
        // zero-length field then a one-byte field
        pkt_q = '{8'h5a, 8'h00, 8'h00, 8'h01, 8'haa};
        send_packet();
        // widest length, packet ends before any payload
        pkt_q = '{8'h01, 8'h02, 8'hff, 8'hff, 8'hff, 8'hff, 8'h0f};
        send_packet();
        // fifth length group overflows, trailing byte drains
        pkt_q = '{8'h7f, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h10, 8'h00};
        send_packet();
        wait_idle();
        write_limit(5'd1);
        // second field exceeds a limit of one
        pkt_q = '{8'h00, 8'h00, 8'h00, 8'h00};
        send_packet();

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            write_limit(limit_plan[p]);
            while (bytes_sent < 25 + (p + 1) * PHASE_BYTES) begin
                make_packet();
                send_packet();
            end
        end

        wait_idle();
        repeat (6) @(posedge aclk);
        if (mismatch_count == 0 && pending == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
